// ===== hdl/lvme_pkg.sv =====
// package for the least-visited maze explorer
// beat types, action and heading codes, register indexes and reset values
// no dependencies
package lvme_pkg;

  // default sizes
  localparam int MAP_SIDE_DEF   = 32;
  localparam int COUNT_BITS_DEF = 10;

  // field widths
  localparam int COORD_W   = 5;
  localparam int HEAD_W    = 2;
  localparam int VISIT_W   = 10;
  localparam int CFG_IDX_W = 2;
  localparam int CFG_DATA_W = 10;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_START_X       = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_START_Y       = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_START_HEADING = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_VISIT_CEILING = 2'd3;

  // reset values of the configuration registers
  localparam int START_X_RST = 11;
  localparam int START_Y_RST = 11;
  localparam logic [HEAD_W-1:0]  START_HEADING_RST = 2'd3;
  localparam logic [VISIT_W-1:0] VISIT_CEILING_RST = 10'd1000;

  // headings
  localparam logic [HEAD_W-1:0] DIR_NORTH = 2'd0;
  localparam logic [HEAD_W-1:0] DIR_EAST  = 2'd1;
  localparam logic [HEAD_W-1:0] DIR_SOUTH = 2'd2;
  localparam logic [HEAD_W-1:0] DIR_WEST  = 2'd3;

  // scan bookkeeping
  localparam logic [2:0] SCAN_TURNS = 3'd4;
  localparam logic [2:0] NO_TURN    = 3'd7;

  typedef enum logic [1:0] {
    ACT_NONE = 2'd0,
    ACT_TURN = 2'd1,
    ACT_MOVE = 2'd2
  } action_e;

  typedef enum logic {
    PH_SCAN  = 1'b0,
    PH_ALIGN = 1'b1
  } phase_e;

  typedef struct packed {
    logic wall_ahead;
    logic at_goal;
  } in_beat_t;

  typedef struct packed {
    logic [1:0]         action;
    logic [HEAD_W-1:0]  heading_now;
    logic [COORD_W-1:0] column_now;
    logic [COORD_W-1:0] row_now;
    logic [VISIT_W-1:0] cell_visits;
  } out_beat_t;

endpackage

// ===== hdl/least_visited_maze_explorer_unit.sv =====
// least-visited maze explorer, top level
// visit map memory, tick decode, read-modify-write stage and output skid
// depends on lvme_pkg
//
// One input beat is one robot tick; every tick gives exactly one result beat. A new tick is
// taken every clock cycle as long as the result side keeps draining, and each result is
// registered: the synchronous read of the visit map happens at the edge that accepted its
// tick, and the compare or increment then feeds the output register, or the skid register
// while the output is stalled. The visit map is a single memory of MAP_SIDE*MAP_SIDE
// counters with one read and one write port; a move writes its incremented counter back in
// the second stage, and a read of the same cell in the cycle of that write is forwarded.
// After reset the map is cleared one entry per cycle, all MAP_SIDE*MAP_SIDE entries (1024 by
// default), and in_stall_o stays high until that pass is done; configuration writes are taken
// during it. Configuration is meant to be written while no tick is in flight.
module least_visited_maze_explorer_unit #(
  parameter int MAP_SIDE   = lvme_pkg::MAP_SIDE_DEF,
  parameter int COUNT_BITS = lvme_pkg::COUNT_BITS_DEF
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               in_valid_i,
  output logic                               in_stall_o,
  input  lvme_pkg::in_beat_t                 in_beat_i,
  output logic                               out_valid_o,
  input  logic                               out_stall_i,
  output lvme_pkg::out_beat_t                out_beat_o,
  input  logic                               cfg_we_i,
  input  logic [lvme_pkg::CFG_IDX_W-1:0]     cfg_idx_i,
  input  logic [lvme_pkg::CFG_DATA_W-1:0]    cfg_data_i
);

  localparam int CW    = $clog2(MAP_SIDE);
  localparam int DEPTH = MAP_SIDE * MAP_SIDE;
  localparam int AW    = $clog2(DEPTH);
  localparam int BW    = (COUNT_BITS > lvme_pkg::VISIT_W) ? COUNT_BITS : lvme_pkg::VISIT_W;
  localparam logic [COUNT_BITS-1:0] COUNT_MAX = {COUNT_BITS{1'b1}};
  localparam logic [CW-1:0] EDGE = CW'(MAP_SIDE - 1);
  localparam logic [CW-1:0] RST_COL =
    (lvme_pkg::START_X_RST >= MAP_SIDE) ? CW'(MAP_SIDE - 1) : CW'(lvme_pkg::START_X_RST);
  localparam logic [CW-1:0] RST_ROW =
    (lvme_pkg::START_Y_RST >= MAP_SIDE) ? CW'(MAP_SIDE - 1) : CW'(lvme_pkg::START_Y_RST);

  typedef struct packed {
    lvme_pkg::action_e               action;
    logic [lvme_pkg::HEAD_W-1:0]     heading;
    logic [CW-1:0]                   col;
    logic [CW-1:0]                   row;
    logic                            is_scan;
    logic                            fresh;
    logic                            do_cmp;
    logic [1:0]                      scan_idx;
    logic                            is_move;
    logic [AW-1:0]                   addr;
  } s1_t;

  function automatic logic [CW-1:0] clamp_coord(logic [lvme_pkg::COORD_W-1:0] v);
    return (int'(v) >= MAP_SIDE) ? CW'(MAP_SIDE - 1) : CW'(v);
  endfunction

  function automatic logic [AW-1:0] cell_addr(logic [CW-1:0] c, logic [CW-1:0] r);
    return AW'(r) * AW'(MAP_SIDE) + AW'(c);
  endfunction

  // robot state
  lvme_pkg::phase_e              phase_q, phase_d;
  logic [lvme_pkg::HEAD_W-1:0]   heading_q, heading_d;
  logic [CW-1:0]                 col_q, col_d, row_q, row_d;
  logic [2:0]                    scan_q, scan_d;
  logic [1:0]                    align_q, align_d, align_eff;
  logic [BW-1:0]                 best_count_q, best_count_nx, base_count;
  logic [2:0]                    best_turn_q, best_turn_nx, base_turn, best_turn_fwd;
  logic [lvme_pkg::VISIT_W-1:0]  ceiling_q;

  // clearing pass
  logic                          clr_active_q;
  logic [AW-1:0]                 clr_addr_q;

  // visit map
  logic [COUNT_BITS-1:0]         visit_mem [DEPTH];
  logic [COUNT_BITS-1:0]         mem_rd_q;
  logic                          wr_en;
  logic [AW-1:0]                 wr_addr, rd_addr;
  logic [COUNT_BITS-1:0]         wr_data;
  logic                          byp_hit_q;
  logic [COUNT_BITS-1:0]         byp_data_q;
  logic [COUNT_BITS-1:0]         rd_cnt, cnt_inc;

  // neighbour ahead
  logic                          nb_ok;
  logic [CW-1:0]                 nb_col, nb_row;

  // pipeline and output
  logic                          in_fire;
  s1_t                           s1_d, s1_q;
  logic                          s1_valid_q;
  lvme_pkg::out_beat_t           res, out_q, skid_q;
  logic                          out_valid_q, skid_valid_q;
  logic                          out_free;

  assign in_stall_o = clr_active_q || skid_valid_q || (s1_valid_q && out_valid_q && out_stall_i);
  assign in_fire    = in_valid_i && !in_stall_o;

  // cell in front of the robot, if it is on the map
  always_comb begin
    nb_ok  = 1'b1;
    nb_col = col_q;
    nb_row = row_q;
    unique case (heading_q)
      lvme_pkg::DIR_NORTH: begin
        if (row_q == '0) nb_ok = 1'b0;
        else nb_row = row_q - CW'(1);
      end
      lvme_pkg::DIR_EAST: begin
        if (col_q == EDGE) nb_ok = 1'b0;
        else nb_col = col_q + CW'(1);
      end
      lvme_pkg::DIR_SOUTH: begin
        if (row_q == EDGE) nb_ok = 1'b0;
        else nb_row = row_q + CW'(1);
      end
      lvme_pkg::DIR_WEST: begin
        if (col_q == '0) nb_ok = 1'b0;
        else nb_col = col_q - CW'(1);
      end
      default: nb_ok = 1'b0;
    endcase
  end

  // a blocked move keeps the position, so the read address is the same either way
  assign rd_addr = cell_addr(nb_ok ? nb_col : col_q, nb_ok ? nb_row : row_q);

  // second stage: compare or increment on the value read
  assign rd_cnt  = byp_hit_q ? byp_data_q : mem_rd_q;
  assign cnt_inc = (rd_cnt == COUNT_MAX) ? rd_cnt : rd_cnt + COUNT_BITS'(1);

  always_comb begin
    base_count    = s1_q.fresh ? BW'(ceiling_q) : best_count_q;
    base_turn     = s1_q.fresh ? lvme_pkg::NO_TURN : best_turn_q;
    best_count_nx = base_count;
    best_turn_nx  = base_turn;
    if (s1_q.do_cmp && (BW'(rd_cnt) < base_count)) begin
      best_count_nx = BW'(rd_cnt);
      best_turn_nx  = {1'b0, s1_q.scan_idx};
    end
    // the scan tick still in flight may change the choice
    best_turn_fwd = (s1_valid_q && s1_q.is_scan) ? best_turn_nx : best_turn_q;
  end

  // first stage: decode the tick against the current state
  always_comb begin
    phase_d   = phase_q;
    heading_d = heading_q;
    col_d     = col_q;
    row_d     = row_q;
    scan_d    = scan_q;
    align_d   = align_q;
    align_eff = '0;
    s1_d      = '0;
    s1_d.action = lvme_pkg::ACT_NONE;
    if (in_beat_i.at_goal) begin
      s1_d.action = lvme_pkg::ACT_NONE;
    end else if ((phase_q == lvme_pkg::PH_SCAN) && (scan_q < lvme_pkg::SCAN_TURNS)) begin
      s1_d.action   = lvme_pkg::ACT_TURN;
      s1_d.is_scan  = 1'b1;
      s1_d.fresh    = (scan_q == '0);
      s1_d.do_cmp   = !in_beat_i.wall_ahead && nb_ok;
      s1_d.scan_idx = scan_q[1:0];
      scan_d        = scan_q + 3'd1;
      heading_d     = heading_q + 2'd1;
    end else begin
      align_eff = (phase_q == lvme_pkg::PH_SCAN) ? 2'd0 : align_q;
      phase_d   = lvme_pkg::PH_ALIGN;
      align_d   = align_eff;
      if ((best_turn_fwd != lvme_pkg::NO_TURN) && (best_turn_fwd > {1'b0, align_eff})) begin
        align_d     = align_eff + 2'd1;
        heading_d   = heading_q + 2'd1;
        s1_d.action = lvme_pkg::ACT_TURN;
      end else begin
        if (nb_ok) begin
          col_d = nb_col;
          row_d = nb_row;
        end
        phase_d      = lvme_pkg::PH_SCAN;
        scan_d       = '0;
        s1_d.action  = lvme_pkg::ACT_MOVE;
        s1_d.is_move = 1'b1;
      end
    end
    s1_d.heading = heading_d;
    s1_d.col     = col_d;
    s1_d.row     = row_d;
    s1_d.addr    = rd_addr;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q      <= lvme_pkg::PH_SCAN;
      heading_q    <= lvme_pkg::START_HEADING_RST;
      col_q        <= RST_COL;
      row_q        <= RST_ROW;
      scan_q       <= '0;
      align_q      <= '0;
      ceiling_q    <= lvme_pkg::VISIT_CEILING_RST;
      best_count_q <= BW'(lvme_pkg::VISIT_CEILING_RST);
      best_turn_q  <= lvme_pkg::NO_TURN;
    end else begin
      if (cfg_we_i) begin
        unique case (cfg_idx_i)
          lvme_pkg::CFG_START_X:       col_q     <= clamp_coord(cfg_data_i[lvme_pkg::COORD_W-1:0]);
          lvme_pkg::CFG_START_Y:       row_q     <= clamp_coord(cfg_data_i[lvme_pkg::COORD_W-1:0]);
          lvme_pkg::CFG_START_HEADING: heading_q <= cfg_data_i[lvme_pkg::HEAD_W-1:0];
          lvme_pkg::CFG_VISIT_CEILING: ceiling_q <= cfg_data_i[lvme_pkg::VISIT_W-1:0];
          default: ;
        endcase
      end else if (in_fire) begin
        phase_q   <= phase_d;
        heading_q <= heading_d;
        col_q     <= col_d;
        row_q     <= row_d;
        scan_q    <= scan_d;
        align_q   <= align_d;
      end
      if (s1_valid_q && s1_q.is_scan) begin
        best_count_q <= best_count_nx;
        best_turn_q  <= best_turn_nx;
      end
    end
  end

  // clearing pass over the visit map
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_active_q <= 1'b1;
      clr_addr_q   <= '0;
    end else if (clr_active_q) begin
      if (clr_addr_q == AW'(DEPTH - 1)) clr_active_q <= 1'b0;
      else clr_addr_q <= clr_addr_q + AW'(1);
    end
  end

  assign wr_en   = clr_active_q || (s1_valid_q && s1_q.is_move);
  assign wr_addr = clr_active_q ? clr_addr_q : s1_q.addr;
  assign wr_data = clr_active_q ? '0 : cnt_inc;

  always_ff @(posedge clk_i) begin
    if (wr_en) visit_mem[wr_addr] <= wr_data;
    if (in_fire) mem_rd_q <= visit_mem[rd_addr];
  end

  // write and read of the same cell in one cycle: take the written value
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      byp_hit_q <= 1'b0;
    end else begin
      byp_hit_q <= wr_en && in_fire && (wr_addr == rd_addr);
    end
  end

  always_ff @(posedge clk_i) begin
    byp_data_q <= wr_data;
  end

  // result of the beat in the second stage
  always_comb begin
    res.action      = s1_q.action;
    res.heading_now = s1_q.heading;
    res.column_now  = lvme_pkg::COORD_W'(s1_q.col);
    res.row_now     = lvme_pkg::COORD_W'(s1_q.row);
    res.cell_visits = s1_q.is_move ? lvme_pkg::VISIT_W'(cnt_inc) : '0;
  end

  assign out_free = !out_valid_q || !out_stall_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q   <= 1'b0;
      out_valid_q  <= 1'b0;
      skid_valid_q <= 1'b0;
    end else begin
      s1_valid_q <= in_fire;
      if (out_free) begin
        if (skid_valid_q) begin
          out_valid_q  <= 1'b1;
          skid_valid_q <= s1_valid_q;
        end else begin
          out_valid_q  <= s1_valid_q;
        end
      end else if (s1_valid_q) begin
        skid_valid_q <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) s1_q <= s1_d;
    if (out_free) begin
      if (skid_valid_q) begin
        out_q <= skid_q;
        if (s1_valid_q) skid_q <= res;
      end else if (s1_valid_q) begin
        out_q <= res;
      end
    end else if (s1_valid_q) begin
      skid_q <= res;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_beat_o  = out_q;

endmodule

// ===== hdl/lvme_checker.sv =====
// port-level checks for the least-visited maze explorer
// bound to least_visited_maze_explorer_unit; depends on lvme_pkg
module lvme_checker (
  input logic                clk_i,
  input logic                rst_ni,
  input logic                in_valid_i,
  input logic                in_stall_o,
  input logic                out_valid_o,
  input logic                out_stall_i,
  input lvme_pkg::out_beat_t out_beat_o
);

  logic       in_fire, out_fire;
  logic [2:0] pend_q;
  logic       last_move_q;

  assign in_fire  = in_valid_i && !in_stall_o;
  assign out_fire = out_valid_o && !out_stall_i;

  // ticks taken but not yet answered
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pend_q      <= '0;
      last_move_q <= 1'b0;
    end else begin
      pend_q <= pend_q + 3'(in_fire) - 3'(out_fire);
      if (out_fire) last_move_q <= (out_beat_o.action == lvme_pkg::ACT_MOVE);
    end
  end

  // the map clear keeps the input stalled right after reset
  a_clear_stall: assert property (@(posedge clk_i) !rst_ni |=> in_stall_o)
    else $error("input not stalled during map clear");

  // no result beat without an earlier accepted tick
  a_no_orphan: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_fire |-> (pend_q != 3'd0))
    else $error("result beat without pending tick");

  // a move always starts a fresh scan, so two moves never follow each other
  a_scan_after_move: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_fire && last_move_q |-> (out_beat_o.action != lvme_pkg::ACT_MOVE))
    else $error("move beat directly after a move beat");

  // a stalled result beat holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(out_beat_o))
    else $error("stalled result beat changed");

endmodule

bind least_visited_maze_explorer_unit lvme_checker u_lvme_checker (.*);

// ===== verif/tb.sv =====
`timescale 1ns / 100ps
// testbench for least_visited_maze_explorer_unit: directed and random robot ticks,
// each result beat checked against a behavioral explorer kept inside this file
// depends on lvme_pkg and the unit under test
module tb;
  import lvme_pkg::*;

  localparam int SIDE = MAP_SIDE_DEF;
  localparam int CELLS = SIDE * SIDE;
  localparam logic [VISIT_W-1:0] VISITS_FULL = VISIT_W'((1 << COUNT_BITS_DEF) - 1);

  logic                  clk_i = 1'b0;
  logic                  rst_ni = 1'b0;
  logic                  in_valid_i = 1'b0;
  logic                  in_stall_o;
  in_beat_t              in_beat_i = '0;
  logic                  out_valid_o;
  logic                  out_stall_i = 1'b0;
  out_beat_t             out_beat_o;
  logic                  cfg_we_i = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_idx_i = '0;
  logic [CFG_DATA_W-1:0] cfg_data_i = '0;

  least_visited_maze_explorer_unit u_top (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_beat_i   (in_beat_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_beat_o  (out_beat_o),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_data_i  (cfg_data_i)
  );

  // explorer state as the testbench sees it
  phase_e             ph;
  logic [HEAD_W-1:0]  hdg;
  logic [COORD_W-1:0] col;
  logic [COORD_W-1:0] rw;
  logic [2:0]         scan_cnt;
  logic [2:0]         best_dir;
  logic [1:0]         align_cnt;
  logic [VISIT_W-1:0] best_cnt;
  logic [VISIT_W-1:0] ceiling;
  logic [VISIT_W-1:0] visits [CELLS];

  in_beat_t  tick_q[$];
  out_beat_t expected_q[$];
  int        fail_count = 0;
  bit        calm = 1'b0;
  logic      in_fire = 1'b0;

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  initial begin
    #1_000_000;
    $display("** least_visited_maze_explorer_unit: FAILED **");
    $finish;
  end

  function automatic bit cell_ahead(input logic [HEAD_W-1:0] dir,
                                    output logic [COORD_W-1:0] nc,
                                    output logic [COORD_W-1:0] nr);
    nc = col;
    nr = rw;
    case (dir)
      DIR_NORTH: begin
        if (rw == 0) return 1'b0;
        nr = rw - 1'b1;
      end
      DIR_EAST: begin
        if (col == SIDE - 1) return 1'b0;
        nc = col + 1'b1;
      end
      DIR_SOUTH: begin
        if (rw == SIDE - 1) return 1'b0;
        nr = rw + 1'b1;
      end
      default: begin
        if (col == 0) return 1'b0;
        nc = col - 1'b1;
      end
    endcase
    return 1'b1;
  endfunction

  function automatic out_beat_t result_now(action_e act, logic [VISIT_W-1:0] v);
    out_beat_t r;
    r.action      = act;
    r.heading_now = hdg;
    r.column_now  = col;
    r.row_now     = rw;
    r.cell_visits = v;
    return r;
  endfunction

  function automatic out_beat_t explore_tick(in_beat_t b);
    logic [COORD_W-1:0] nc;
    logic [COORD_W-1:0] nr;
    logic [VISIT_W-1:0] cnt;
    int                 idx;
    if (b.at_goal) return result_now(ACT_NONE, '0);
    if (ph == PH_SCAN) begin
      if (scan_cnt == 0) begin
        best_cnt = ceiling;
        best_dir = NO_TURN;
      end
      if (scan_cnt < SCAN_TURNS) begin
        if (!b.wall_ahead && cell_ahead(hdg, nc, nr)) begin
          cnt = visits[int'(nr) * SIDE + int'(nc)];
          if (cnt < best_cnt) begin
            best_cnt = cnt;
            best_dir = scan_cnt;
          end
        end
        scan_cnt = scan_cnt + 1'b1;
        hdg      = hdg + 1'b1;
        return result_now(ACT_TURN, '0);
      end
      ph        = PH_ALIGN;
      align_cnt = '0;
    end
    if (best_dir != NO_TURN && best_dir > align_cnt) begin
      align_cnt = align_cnt + 1'b1;
      hdg       = hdg + 1'b1;
      return result_now(ACT_TURN, '0);
    end
    // off-map move keeps the position and bumps the current cell
    if (cell_ahead(hdg, nc, nr)) begin
      col = nc;
      rw  = nr;
    end
    idx = int'(rw) * SIDE + int'(col);
    cnt = visits[idx];
    if (cnt < VISITS_FULL) cnt = cnt + 1'b1;
    visits[idx] = cnt;
    ph          = PH_SCAN;
    scan_cnt    = '0;
    return result_now(ACT_MOVE, cnt);
  endfunction

  // 5-bit coordinates never reach SIDE, so no clamping is needed here
  function automatic void apply_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
    case (idx)
      CFG_START_X:       col = data[COORD_W-1:0];
      CFG_START_Y:       rw = data[COORD_W-1:0];
      CFG_START_HEADING: hdg = data[HEAD_W-1:0];
      CFG_VISIT_CEILING: ceiling = data[VISIT_W-1:0];
      default: ;
    endcase
  endfunction

  function automatic void check_field(string name, logic [VISIT_W-1:0] want,
                                      logic [VISIT_W-1:0] got);
    if (got !== want) begin
      fail_count++;
      $error("%s: expected %0d, got %0d", name, want, got);
    end
  endfunction

  // result check, config tracking and tick prediction
  always @(posedge clk_i) begin
    out_beat_t want;
    in_fire <= rst_ni && in_valid_i && !in_stall_o;
    if (rst_ni) begin
      if (out_valid_o && !out_stall_i) begin
        if (expected_q.size() == 0) begin
          fail_count++;
          $error("result beat with nothing expected");
        end else begin
          want = expected_q.pop_front();
          check_field("action", VISIT_W'(want.action), VISIT_W'(out_beat_o.action));
          check_field("heading_now", VISIT_W'(want.heading_now),
                      VISIT_W'(out_beat_o.heading_now));
          check_field("column_now", VISIT_W'(want.column_now),
                      VISIT_W'(out_beat_o.column_now));
          check_field("row_now", VISIT_W'(want.row_now), VISIT_W'(out_beat_o.row_now));
          check_field("cell_visits", want.cell_visits, out_beat_o.cell_visits);
        end
      end
      if (cfg_we_i) apply_reg(cfg_idx_i, cfg_data_i);
      if (in_valid_i && !in_stall_o) expected_q.push_back(explore_tick(in_beat_i));
    end
  end

  // tick driver: next beat only once the current one is taken
  always @(negedge clk_i) begin
    if (rst_ni && (!in_valid_i || in_fire)) begin
      if (tick_q.size() != 0 && (calm || $urandom_range(99) >= 24)) begin
        in_valid_i <= 1'b1;
        in_beat_i  <= tick_q.pop_front();
      end else begin
        in_valid_i <= 1'b0;
      end
    end
  end

  always @(negedge clk_i) begin
    out_stall_i <= !calm && ($urandom_range(99) < 24);
  end

  task automatic add_tick(bit wall, bit goal);
    in_beat_t b;
    b.wall_ahead = wall;
    b.at_goal    = goal;
    tick_q.push_back(b);
  endtask

  task automatic queue_ticks(int n, int goal_pct, int wall_pct);
    for (int i = 0; i < n; i++)
      add_tick($urandom_range(99) < wall_pct, $urandom_range(99) < goal_pct);
  endtask

  task automatic drain();
    while (tick_q.size() != 0 || in_valid_i || expected_q.size() != 0) @(posedge clk_i);
  endtask

  // step with walls all around until the robot stands at the start of a scan
  task automatic finish_scan();
    while (!(ph == PH_SCAN && scan_cnt == 0)) begin
      add_tick(1'b1, 1'b0);
      drain();
    end
  endtask

  // upper data bits of the coordinate and heading writes are random: only their low bits count
  task automatic program_regs(input logic [3:0] mask, input logic [COORD_W-1:0] x,
                              input logic [COORD_W-1:0] y, input logic [HEAD_W-1:0] h,
                              input logic [VISIT_W-1:0] c);
    logic [CFG_IDX_W-1:0]  regs [4];
    logic [CFG_DATA_W-1:0] vals [4];
    regs[0] = CFG_START_X;
    regs[1] = CFG_START_Y;
    regs[2] = CFG_START_HEADING;
    regs[3] = CFG_VISIT_CEILING;
    vals[0] = CFG_DATA_W'($urandom);
    vals[1] = CFG_DATA_W'($urandom);
    vals[2] = CFG_DATA_W'($urandom);
    vals[0][COORD_W-1:0] = x;
    vals[1][COORD_W-1:0] = y;
    vals[2][HEAD_W-1:0]  = h;
    vals[3] = c;
    for (int i = 0; i < 4; i++) begin
      if (mask[i]) begin
        @(negedge clk_i);
        cfg_we_i   <= 1'b1;
        cfg_idx_i  <= regs[i];
        cfg_data_i <= vals[i];
      end
    end
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  function automatic logic [COORD_W-1:0] pick_coord();
    int r;
    r = $urandom_range(9);
    if (r == 0) return '0;
    if (r == 1) return COORD_W'(SIDE - 1);
    return COORD_W'($urandom_range(SIDE - 1));
  endfunction

  function automatic logic [VISIT_W-1:0] pick_ceiling();
    case ($urandom_range(5))
      0: return 10'd1;
      1: return 10'd1023;
      2: return VISIT_CEILING_RST;
      3: return VISIT_W'($urandom_range(8, 1));
      default: return VISIT_W'($urandom_range(1023, 1));
    endcase
  endfunction

  initial begin
    ph        = PH_SCAN;
    hdg       = START_HEADING_RST;
    col       = COORD_W'(START_X_RST);
    rw        = COORD_W'(START_Y_RST);
    scan_cnt  = '0;
    ceiling   = VISIT_CEILING_RST;
    best_cnt  = VISIT_CEILING_RST;
    best_dir  = NO_TURN;
    align_cnt = '0;
    foreach (visits[i]) visits[i] = '0;

    repeat (8) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // reset configuration: goal ticks, a scan with mixed walls, then an open one
    add_tick(1'b0, 1'b1);
    add_tick(1'b1, 1'b1);
    add_tick(1'b0, 1'b0);
    add_tick(1'b1, 1'b0);
    add_tick(1'b0, 1'b0);
    add_tick(1'b1, 1'b0);
    add_tick(1'b1, 1'b0);
    add_tick(1'b0, 1'b0);
    add_tick(1'b0, 1'b0);
    add_tick(1'b0, 1'b1);
    queue_ticks(4, 0, 0);
    drain();

    // far corner: two neighbours off the map, then nothing open at all
    program_regs(4'hf, COORD_W'(SIDE - 1), COORD_W'(SIDE - 1), DIR_EAST, 10'd1023);
    queue_ticks(6, 0, 0);
    queue_ticks(5, 0, 100);
    drain();

    // walled in at the origin facing north: every move bumps the same cell
    finish_scan();
    program_regs(4'hf, '0, '0, DIR_NORTH, 10'd1);
    queue_ticks(100, 1, 100);
    drain();

    // zero ceiling: nothing is ever chosen, robot keeps bumping against the east edge
    finish_scan();
    program_regs(4'hf, COORD_W'(SIDE - 1), '0, DIR_EAST, '0);
    queue_ticks(15, 0, 0);
    drain();

    for (int p = 0; p < 6; p++) begin
      calm = (p == 3);
      program_regs(($urandom_range(3) == 0) ? 4'hf : 4'($urandom_range(15)),
                   pick_coord(), pick_coord(), HEAD_W'($urandom_range(3)), pick_ceiling());
      // one goal-heavy noisy stretch, otherwise mostly exploring ticks
      if (p == 4) queue_ticks(150, 40, 60);
      else queue_ticks(150, 4, 30);
      drain();
    end
    calm = 1'b0;

    repeat (8) @(posedge clk_i);
    if (fail_count == 0) begin
      $display("** least_visited_maze_explorer_unit: PASSED **");
    end else begin
      $display("** least_visited_maze_explorer_unit: FAILED **");
    end
    $finish;
  end

endmodule
